@@ src/ddalr_pkg.sv @@
// shared types, constants and codes of the dda line rasterizer
package ddalr_pkg;

    // image size and fixed-point fraction width
    localparam int IMAGE_WIDTH  = 512;
    localparam int IMAGE_HEIGHT = 512;
    localparam int FRAC_BITS    = 16;

    // coordinate, accumulator and increment widths
    localparam int COORD_W = 12;
    localparam int DIFF_W  = COORD_W + 1;
    localparam int ACC_W   = COORD_W + FRAC_BITS;
    localparam int QUO_W   = FRAC_BITS + 1;
    localparam int INC_W   = FRAC_BITS + 2;
    localparam int CNT_W   = $clog2(FRAC_BITS + 1);
    localparam int RGB_W   = 24;

    // configuration port
    localparam int PADDR_W   = 3;
    localparam int PDATA_W   = 32;
    localparam int REG_IDX_W = 1;

    localparam logic [REG_IDX_W-1:0] REG_USE_CUSTOM   = 1'b0;
    localparam logic [REG_IDX_W-1:0] REG_CUSTOM_COLOR = 1'b1;

    // word actions
    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_STEP = 1'b1;

    localparam logic [RGB_W-1:0] GREEN_RGB = 24'h00FF00;

    typedef struct packed {
        logic                      action;
        logic signed [COORD_W-1:0] start_x;
        logic signed [COORD_W-1:0] start_y;
        logic signed [COORD_W-1:0] end_x;
        logic signed [COORD_W-1:0] end_y;
    } ddalr_in_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] pixel_x;
        logic signed [COORD_W-1:0] pixel_y;
        logic        [RGB_W-1:0]   pixel_rgb;
        logic                      in_image;
        logic                      last_pixel;
    } ddalr_out_t;

    typedef struct packed {
        logic             use_custom_color;
        logic [RGB_W-1:0] custom_color;
    } ddalr_cfg_t;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic div_step;
        logic div_fin;
        logic step;
    } ddalr_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic zero_len;
        logic out_busy;
    } ddalr_sts_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_FIN
    } ddalr_state_t;

endpackage

@@ src/ddalr_ctrl.sv @@
// controller state machine: word acceptance and divider sequencing
module ddalr_ctrl (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic                    s_action,
    input  ddalr_pkg::ddalr_sts_t   sts,
    output ddalr_pkg::ddalr_cmd_t   cmd
);

    ddalr_pkg::ddalr_state_t state_reg, state_next;
    logic [ddalr_pkg::CNT_W-1:0] cnt_reg, cnt_next;
    logic accept;

    // state and iteration counter
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ddalr_pkg::ST_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    assign accept = s_valid && s_ready;

    // next state and commands
    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        s_ready    = 1'b0;
        cmd        = '0;
        unique case (state_reg)
            ddalr_pkg::ST_IDLE: begin
                s_ready = !sts.out_busy;
                if (s_valid && s_ready) begin
                    if (s_action == ddalr_pkg::ACT_LOAD) begin
                        cmd.load = 1'b1;
                        if (!sts.zero_len) begin
                            state_next = ddalr_pkg::ST_DIV;
                            cnt_next   = ddalr_pkg::CNT_W'(ddalr_pkg::FRAC_BITS);
                        end
                    end else begin
                        cmd.step = 1'b1;
                    end
                end
            end
            ddalr_pkg::ST_DIV: begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg - 1'b1;
                if (cnt_reg == '0) begin
                    state_next = ddalr_pkg::ST_FIN;
                end
            end
            ddalr_pkg::ST_FIN: begin
                cmd.div_fin = 1'b1;
                state_next  = ddalr_pkg::ST_IDLE;
            end
            default: begin
                state_next = ddalr_pkg::ST_IDLE;
            end
        endcase
    end

`ifndef SYNTHESIS
    // a load of a real line starts the divider with a full count
    a_load_starts_div: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_action == ddalr_pkg::ACT_LOAD && !sts.zero_len) |=>
        (state_reg == ddalr_pkg::ST_DIV &&
         cnt_reg == ddalr_pkg::CNT_W'(ddalr_pkg::FRAC_BITS)))
        else $error("load did not start divider");

    // divider counts down one per cycle until its last iteration
    a_div_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ddalr_pkg::ST_DIV && cnt_reg != '0) |=>
        (state_reg == ddalr_pkg::ST_DIV && cnt_reg == $past(cnt_reg) - 1'b1))
        else $error("divider count broken");

    // sign fix returns to idle in the next cycle
    a_fin_one_cycle: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ddalr_pkg::ST_FIN) |=> (state_reg == ddalr_pkg::ST_IDLE))
        else $error("sign fix did not return to idle");
`endif

endmodule

@@ src/ddalr_datapath.sv @@
// datapath: endpoint setup, restoring divider, accumulators and pixel register
module ddalr_datapath (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  ddalr_pkg::ddalr_in_t   s_data,
    input  logic                   m_ready,
    output logic                   m_valid,
    output ddalr_pkg::ddalr_out_t  m_data,
    input  ddalr_pkg::ddalr_cfg_t  cfg,
    input  ddalr_pkg::ddalr_cmd_t  cmd,
    output ddalr_pkg::ddalr_sts_t  sts
);

    localparam int COORD_W = ddalr_pkg::COORD_W;
    localparam int DIFF_W  = ddalr_pkg::DIFF_W;
    localparam int ACC_W   = ddalr_pkg::ACC_W;
    localparam int QUO_W   = ddalr_pkg::QUO_W;
    localparam int INC_W   = ddalr_pkg::INC_W;
    localparam int FRAC    = ddalr_pkg::FRAC_BITS;
    localparam logic [DIFF_W-1:0] IMG_W_LIM = DIFF_W'(ddalr_pkg::IMAGE_WIDTH);
    localparam logic [DIFF_W-1:0] IMG_H_LIM = DIFF_W'(ddalr_pkg::IMAGE_HEIGHT);

    logic [ACC_W-1:0]  x_acc_reg, x_acc_next, y_acc_reg, y_acc_next;
    logic [INC_W-1:0]  x_inc_reg, x_inc_next, y_inc_reg, y_inc_next;
    logic [DIFF_W-1:0] steps_left_reg, steps_left_next;
    logic [DIFF_W-1:0] den_reg, den_next;
    logic [DIFF_W-1:0] x_rem_reg, x_rem_next, y_rem_reg, y_rem_next;
    logic [QUO_W-1:0]  x_quo_reg, x_quo_next, y_quo_reg, y_quo_next;
    logic              x_neg_reg, x_neg_next, y_neg_reg, y_neg_next;
    logic              m_valid_reg, m_valid_next;
    ddalr_pkg::ddalr_out_t out_reg, out_next;

    logic [DIFF_W-1:0]  dx, dy, adx, ady, len;
    logic               x_ge, y_ge;
    logic [DIFF_W-1:0]  x_sub, y_sub;
    logic [COORD_W-1:0] px, py;
    logic               on_image;

    // endpoint differences and line length
    always_comb begin
        dx  = {s_data.end_x[COORD_W-1], s_data.end_x}
            - {s_data.start_x[COORD_W-1], s_data.start_x};
        dy  = {s_data.end_y[COORD_W-1], s_data.end_y}
            - {s_data.start_y[COORD_W-1], s_data.start_y};
        adx = dx[DIFF_W-1] ? -dx : dx;
        ady = dy[DIFF_W-1] ? -dy : dy;
        len = (adx > ady) ? adx : ady;
    end

    // one quotient bit per cycle for both axes
    always_comb begin
        x_ge  = x_rem_reg >= den_reg;
        y_ge  = y_rem_reg >= den_reg;
        x_sub = x_ge ? x_rem_reg - den_reg : x_rem_reg;
        y_sub = y_ge ? y_rem_reg - den_reg : y_rem_reg;
    end

    // pixel position, truncated toward zero, and image test
    always_comb begin
        px = x_acc_reg[ACC_W-1:FRAC]
           + {{(COORD_W-1){1'b0}}, x_acc_reg[ACC_W-1] & (|x_acc_reg[FRAC-1:0])};
        py = y_acc_reg[ACC_W-1:FRAC]
           + {{(COORD_W-1){1'b0}}, y_acc_reg[ACC_W-1] & (|y_acc_reg[FRAC-1:0])};
        on_image = !px[COORD_W-1] && ({1'b0, px} < IMG_W_LIM)
                && !py[COORD_W-1] && ({1'b0, py} < IMG_H_LIM);
    end

    // next values of the line state
    always_comb begin
        x_acc_next      = x_acc_reg;
        y_acc_next      = y_acc_reg;
        x_inc_next      = x_inc_reg;
        y_inc_next      = y_inc_reg;
        steps_left_next = steps_left_reg;
        den_next        = den_reg;
        x_rem_next      = x_rem_reg;
        y_rem_next      = y_rem_reg;
        x_quo_next      = x_quo_reg;
        y_quo_next      = y_quo_reg;
        x_neg_next      = x_neg_reg;
        y_neg_next      = y_neg_reg;
        out_next        = out_reg;
        m_valid_next    = m_valid_reg && !m_ready;

        if (cmd.load) begin
            x_acc_next      = {s_data.start_x, {FRAC{1'b0}}};
            y_acc_next      = {s_data.start_y, {FRAC{1'b0}}};
            steps_left_next = len;
            den_next        = len;
            x_rem_next      = adx;
            y_rem_next      = ady;
            x_neg_next      = dx[DIFF_W-1];
            y_neg_next      = dy[DIFF_W-1];
        end

        if (cmd.div_step) begin
            x_quo_next = {x_quo_reg[QUO_W-2:0], x_ge};
            y_quo_next = {y_quo_reg[QUO_W-2:0], y_ge};
            x_rem_next = {x_sub[DIFF_W-2:0], 1'b0};
            y_rem_next = {y_sub[DIFF_W-2:0], 1'b0};
        end

        if (cmd.div_fin) begin
            x_inc_next = x_neg_reg ? -{1'b0, x_quo_reg} : {1'b0, x_quo_reg};
            y_inc_next = y_neg_reg ? -{1'b0, y_quo_reg} : {1'b0, y_quo_reg};
        end

        if (cmd.step && steps_left_reg != '0) begin
            out_next.pixel_x    = px;
            out_next.pixel_y    = py;
            out_next.pixel_rgb  = cfg.use_custom_color ? cfg.custom_color
                                                       : ddalr_pkg::GREEN_RGB;
            out_next.in_image   = on_image;
            out_next.last_pixel = steps_left_reg == DIFF_W'(1);
            m_valid_next        = 1'b1;
            x_acc_next = x_acc_reg + {{(ACC_W-INC_W){x_inc_reg[INC_W-1]}}, x_inc_reg};
            y_acc_next = y_acc_reg + {{(ACC_W-INC_W){y_inc_reg[INC_W-1]}}, y_inc_reg};
            steps_left_next = steps_left_reg - 1'b1;
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            x_acc_reg      <= '0;
            y_acc_reg      <= '0;
            x_inc_reg      <= '0;
            y_inc_reg      <= '0;
            steps_left_reg <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            x_acc_reg      <= x_acc_next;
            y_acc_reg      <= y_acc_next;
            x_inc_reg      <= x_inc_next;
            y_inc_reg      <= y_inc_next;
            steps_left_reg <= steps_left_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    // divider and result payload registers
    always_ff @(posedge aclk) begin
        den_reg   <= den_next;
        x_rem_reg <= x_rem_next;
        y_rem_reg <= y_rem_next;
        x_quo_reg <= x_quo_next;
        y_quo_reg <= y_quo_next;
        x_neg_reg <= x_neg_next;
        y_neg_reg <= y_neg_next;
        out_reg   <= out_next;
    end

    assign m_valid      = m_valid_reg;
    assign m_data       = out_reg;
    assign sts.zero_len = (len == '0);
    assign sts.out_busy = m_valid_reg && !m_ready;

`ifndef SYNTHESIS
    // each emitted pixel uses up exactly one step
    a_step_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.step && !cmd.load && steps_left_reg != '0) |=>
        (m_valid_reg && steps_left_reg == $past(steps_left_reg) - 1'b1))
        else $error("step count not decremented with pixel");
`endif

endmodule

@@ src/dda_line_rasterizer.sv @@
// top level: configuration registers, controller and datapath
//
// DDA line rasterizer. A load word (action 0) takes two signed endpoints and
// sets up per-step increments with a restoring divider that yields one
// quotient bit per cycle for x and y together; after a load, input is held
// off while the divider and the sign fix run, or not at all when the
// endpoints are equal. A step word (action 1) produces one pixel from the
// x/y accumulators and is taken every cycle while the result side keeps up;
// the result register lets the next word in during the cycle its result is
// taken. Steps with no active line are absorbed with no result. The far
// endpoint is never emitted, the last pixel of a line carries last_pixel,
// and pixels off the image come out with in_image low. Colour is green
// unless use_custom_color (address 0x0) is set, in which case custom_color
// (address 0x4) is used.
module dda_line_rasterizer (
    input  logic                                aclk,
    input  logic                                aresetn,
    // input words
    input  logic                                s_valid,
    output logic                                s_ready,
    input  ddalr_pkg::ddalr_in_t                s_data,
    // result words
    output logic                                m_valid,
    input  logic                                m_ready,
    output ddalr_pkg::ddalr_out_t               m_data,
    // configuration
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [ddalr_pkg::PADDR_W-1:0]       paddr,
    input  logic [ddalr_pkg::PDATA_W-1:0]       pwdata,
    output logic [ddalr_pkg::PDATA_W-1:0]       prdata,
    output logic                                pready
);

    ddalr_pkg::ddalr_cfg_t cfg_reg, cfg_next;
    ddalr_pkg::ddalr_cmd_t cmd;
    ddalr_pkg::ddalr_sts_t sts;
    logic [ddalr_pkg::REG_IDX_W-1:0] reg_idx;
    logic wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[2];
    assign wr_en   = psel && penable && pwrite;

    // register write decode
    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            unique case (reg_idx)
                ddalr_pkg::REG_USE_CUSTOM:   cfg_next.use_custom_color = pwdata[0];
                ddalr_pkg::REG_CUSTOM_COLOR:
                    cfg_next.custom_color = pwdata[ddalr_pkg::RGB_W-1:0];
                default: cfg_next = cfg_reg;
            endcase
        end
    end

    // register read decode
    always_comb begin
        unique case (reg_idx)
            ddalr_pkg::REG_USE_CUSTOM:
                prdata = {{(ddalr_pkg::PDATA_W-1){1'b0}}, cfg_reg.use_custom_color};
            ddalr_pkg::REG_CUSTOM_COLOR:
                prdata = {{(ddalr_pkg::PDATA_W-ddalr_pkg::RGB_W){1'b0}},
                          cfg_reg.custom_color};
            default: prdata = '0;
        endcase
    end

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    ddalr_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_action (s_data.action),
        .sts      (sts),
        .cmd      (cmd)
    );

    ddalr_datapath u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .m_ready (m_ready),
        .m_valid (m_valid),
        .m_data  (m_data),
        .cfg     (cfg_reg),
        .cmd     (cmd),
        .sts     (sts)
    );

endmodule
